FILE: rtl/vsc_pkg.sv
`default_nettype none

package vsc_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int SEGMENT_BITS_DEF = 31;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [1:0] ORD_EQUAL  = 2'b00;
    localparam logic [1:0] ORD_FIRST  = 2'b01;
    localparam logic [1:0] ORD_SECOND = 2'b11;

endpackage

`default_nettype wire

FILE: rtl/version_string_compare.sv
`default_nettype none

// Dotted version compare. Characters of the first version (mode 0) and then of
// the second (mode 1) arrive one beat at a time; the result beat (order 1, 0 or -1
// and the segment overflow flag) follows the last character of the second string.
// Each character is taken in an accept step and then processed in S_CHAR. The
// end of the first string adds a step (S_CLOSE) that writes the closing segment
// into the segment store. In the second string every segment end passes through S_SEG
// and S_CMP because the stored value comes through the registered read port of the single-port store.
// After the final character, the stored segments beyond those the second string
// covered are scanned through S_SCAN and S_SCHK (stopping once the order is decided);
// then S_SCAN ends the scan and S_OUT loads the output register. S_OUT
// repeats for as long as an earlier result still waits in the output
// register. The store needs no clearing after reset; a new input beat is taken
// while a result still waits in the output register.
module version_string_compare
    import vsc_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int SEGMENT_BITS = SEGMENT_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_mode,
    input  wire logic [7:0]        i_ch,
    input  wire logic              i_last,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic signed [1:0]      o_order,
    output logic                   o_segment_overflow
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHAR  = 3'd1;
    localparam logic [2:0] S_CLOSE = 3'd2;
    localparam logic [2:0] S_SEG   = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_SCHK  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]              r_state, n_state;
    logic                    r_mode, n_mode;
    logic [7:0]              r_ch, n_ch;
    logic                    r_last, n_last;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [SEGMENT_BITS-1:0] r_accum, n_accum;
    logic [CNT_W-1:0]        r_sidx, n_sidx;
    logic [1:0]              r_order, n_order;
    logic                    r_ovf, n_ovf;
    logic                    r_done, n_done;
    logic [1:0]              r_ends, n_ends;
    logic                    r_out_valid, n_out_valid;
    logic [1:0]              r_out_order, n_out_order;
    logic                    r_out_ovf, n_out_ovf;

    logic [SEGMENT_BITS-1:0] r_mem [MAX_SEGMENTS];
    logic [SEGMENT_BITS-1:0] r_rd;

    logic                    w_accept;
    logic                    w_is_digit;
    logic                    w_is_dot;
    logic [7:0]              w_sub;
    logic [SEGMENT_BITS-1:0] w_acc_next;
    logic [SEGMENT_BITS-1:0] w_stored;
    logic                    w_mem_we;
    logic                    w_mem_re;
    logic                    w_scan_go;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_digit = r_ch inside {[CH_ZERO:CH_NINE]};
    assign w_is_dot   = (r_ch == CH_DOT);
    assign w_sub      = r_ch - CH_ZERO;
    assign w_stored   = (r_sidx < r_count) ? r_rd : '0;
    assign w_scan_go  = (r_sidx < r_count) && (r_order == ORD_EQUAL);

    vsc_accum #(
        .SEGMENT_BITS(SEGMENT_BITS)
    ) u_accum (
        .i_accum(r_accum),
        .i_digit(w_sub[3:0]),
        .o_accum(w_acc_next)
    );

    assign w_mem_we = (((r_state == S_CHAR) && !r_mode && w_is_dot) || (r_state == S_CLOSE))
                      && (r_count < CNT_MAX);
    assign w_mem_re = (r_state == S_SEG) || ((r_state == S_SCAN) && w_scan_go);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[IDX_W-1:0]] <= r_accum;
        end
        if (w_mem_re) begin
            r_rd <= r_mem[r_sidx[IDX_W-1:0]];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_ch        = r_ch;
        n_last      = r_last;
        n_count     = r_count;
        n_accum     = r_accum;
        n_sidx      = r_sidx;
        n_order     = r_order;
        n_ovf       = r_ovf;
        n_done      = r_done;
        n_ends      = r_ends;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_order = r_out_order;
        n_out_ovf   = r_out_ovf;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode = i_mode;
                    n_ch   = i_ch;
                    n_last = i_last;
                    if (!i_mode && r_done) begin
                        n_count = '0;
                        n_accum = '0;
                        n_sidx  = '0;
                        n_order = ORD_EQUAL;
                        n_ovf   = 1'b0;
                        n_done  = 1'b0;
                    end
                    n_state = (i_mode && !r_done) ? S_CLOSE : S_CHAR;
                end
            end
            S_CHAR: begin
                if (w_is_digit) begin
                    n_accum = w_acc_next;
                end
                if (!r_mode) begin
                    if (w_is_dot) begin
                        if (r_count < CNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_accum = '0;
                    end
                    n_state = r_last ? S_CLOSE : S_IDLE;
                end else begin
                    n_ends  = {1'b0, w_is_dot} + {1'b0, r_last};
                    n_state = (w_is_dot || r_last) ? S_SEG : S_IDLE;
                end
            end
            S_CLOSE: begin
                if (r_count < CNT_MAX) begin
                    n_count = r_count + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                n_accum = '0;
                n_done  = 1'b1;
                n_sidx  = '0;
                n_order = ORD_EQUAL;
                n_state = r_mode ? S_CHAR : S_IDLE;
            end
            S_SEG: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_order == ORD_EQUAL) begin
                    if (w_stored > r_accum) begin
                        n_order = ORD_FIRST;
                    end else if (w_stored < r_accum) begin
                        n_order = ORD_SECOND;
                    end
                end
                if (r_sidx < CNT_MAX) begin
                    n_sidx = r_sidx + 1'b1;
                end
                n_accum = '0;
                n_ends  = r_ends - 1'b1;
                if (r_ends == 2'd2) begin
                    n_state = S_SEG;
                end else begin
                    n_state = r_last ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN: begin
                n_state = w_scan_go ? S_SCHK : S_OUT;
            end
            S_SCHK: begin
                if (r_rd != '0) begin
                    n_order = ORD_FIRST;
                end
                n_sidx  = r_sidx + 1'b1;
                n_state = S_SCAN;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_order = r_order;
                    n_out_ovf   = r_ovf;
                    n_count     = '0;
                    n_accum     = '0;
                    n_sidx      = '0;
                    n_order     = ORD_EQUAL;
                    n_ovf       = 1'b0;
                    n_done      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_accum     <= '0;
            r_sidx      <= '0;
            r_order     <= ORD_EQUAL;
            r_ovf       <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_accum     <= n_accum;
            r_sidx      <= n_sidx;
            r_order     <= n_order;
            r_ovf       <= n_ovf;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_ch        <= n_ch;
        r_last      <= n_last;
        r_ends      <= n_ends;
        r_out_order <= n_out_order;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_order            = r_out_order;
    assign o_segment_overflow = r_out_ovf;

endmodule

`default_nettype wire

FILE: rtl/vsc_accum.sv
`default_nettype none

module vsc_accum
    import vsc_pkg::*;
#(
    parameter int SEGMENT_BITS = SEGMENT_BITS_DEF
) (
    input  wire logic [SEGMENT_BITS-1:0] i_accum,
    input  wire logic [3:0]              i_digit,
    output logic      [SEGMENT_BITS-1:0] o_accum
);

    logic [SEGMENT_BITS+3:0] w_wide;

    // Times ten is eight times plus two times; anything above the segment width saturates.
    assign w_wide = {1'b0, i_accum, 3'b000} + {3'b000, i_accum, 1'b0}
                  + {{SEGMENT_BITS{1'b0}}, i_digit};

    assign o_accum = (|w_wide[SEGMENT_BITS+3:SEGMENT_BITS]) ? {SEGMENT_BITS{1'b1}}
                                                            : w_wide[SEGMENT_BITS-1:0];

endmodule

`default_nettype wire

FILE: rtl/vsc_checker.sv
`default_nettype none

module vsc_checker
    import vsc_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic signed [1:0] o_order,
    input wire logic              o_segment_overflow
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk)
        (i_rst_n && o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_order) && $stable(o_segment_overflow)))
        else $error("result beat changed while stalled");

    // The order is always one of the three legal codes.
    a_order_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_order == ORD_EQUAL) || (o_order == ORD_FIRST)
                         || (o_order == ORD_SECOND)))
        else $error("illegal order code");

    // The block is busy in the cycle after every accepted character.
    a_busy_after_accept: assert property (@(posedge i_clk)
        (i_rst_n && i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted beat");

    // A new result is loaded only at the end of processing, never from idle.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while the block was idle");

endmodule

bind version_string_compare vsc_checker u_vsc_checker (.*);

`default_nettype wire
